@@ rtl/core/jse_pkg.sv @@
package jse_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int NUM_HELD  = 3;

    typedef logic [2:0] t_slot_idx;

    localparam t_slot_idx SLOT_OPEN  = 3'd0;
    localparam t_slot_idx SLOT_H0    = 3'd1;
    localparam t_slot_idx SLOT_B     = 3'd4;
    localparam t_slot_idx SLOT_CLOSE = 3'd5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [2:0] {
        M_NONE,
        M_QUOTE,
        M_RAW,
        M_SHORT,
        M_HEX
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] data;
    } t_slot;

    typedef struct packed {
        t_slot [NUM_SLOTS-1:0] slots;
    } t_plan;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h57 + {4'd0, nib};
        end
        return r;
    endfunction

    function automatic logic [2:0] slot_len(input t_mode mode);
        logic [2:0] r;
        unique case (mode)
            M_QUOTE: r = 3'd1;
            M_RAW:   r = 3'd1;
            M_SHORT: r = 3'd2;
            M_HEX:   r = 3'd6;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] slot_byte(input t_mode mode, input logic [7:0] data,
                                             input logic [2:0] sub);
        logic [7:0] r;
        unique case (mode)
            M_QUOTE: r = CH_QUOTE;
            M_RAW:   r = data;
            M_SHORT: r = (sub == 3'd0) ? CH_BSLASH : data;
            M_HEX: begin
                unique case (sub)
                    3'd0:    r = CH_BSLASH;
                    3'd1:    r = CH_U;
                    3'd2:    r = CH_ZERO;
                    3'd3:    r = CH_ZERO;
                    3'd4:    r = hex_digit(data[7:4]);
                    default: r = hex_digit(data[3:0]);
                endcase
            end
            default: r = data;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/jse_stream_if.sv @@
interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       end_of_string;

    modport source (output valid, data_byte, carries_byte, end_of_string, input ready);
    modport sink   (input valid, data_byte, carries_byte, end_of_string, output ready);
endinterface

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_closed;

    modport source (output valid, out_byte, last_of_run, string_closed, input ready);
    modport sink   (input valid, out_byte, last_of_run, string_closed, output ready);
endinterface

@@ rtl/core/jse_plan.sv @@
module jse_plan
    import jse_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    jse_in_if.sink i_item,
    input  logic   i_take,
    output logic   o_plan_valid,
    output t_plan  o_plan
);

    logic [7:0] r_held [NUM_HELD];
    logic [1:0] r_held_count;
    logic [2:0] r_seq_len;
    logic       r_inside;
    logic       r_plan_valid;
    t_plan      r_plan;

    logic [1:0] n_held_count;
    logic [2:0] n_seq_len;
    logic       n_inside;
    t_plan      n_plan;
    logic       n_store;
    logic [1:0] n_store_idx;

    logic       accept;
    logic       any_slot;

    assign i_item.ready = !r_plan_valid || i_take;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        logic [7:0] b;
        logic [7:0] lead;
        logic       pending;
        logic       ok;
        logic [7:0] esc;
        logic       is_lead;
        logic [2:0] lead_len;
        t_mode      held_mode;
        t_mode      b_mode;
        logic [7:0] b_data;

        b        = i_item.data_byte;
        lead     = r_held[0];
        pending  = r_held_count != 2'd0;
        is_lead  = (b >= 8'hc2) && (b <= 8'hf4);
        lead_len = (b < 8'he0) ? 3'd2 : (b < 8'hf0) ? 3'd3 : 3'd4;

        priority if (r_held_count == 2'd1 && lead == 8'he0) begin
            ok = (b >= 8'ha0) && (b <= 8'hbf);
        end else if (r_held_count == 2'd1 && lead == 8'hed) begin
            ok = (b >= 8'h80) && (b <= 8'h9f);
        end else if (r_held_count == 2'd1 && lead == 8'hf0) begin
            ok = (b >= 8'h90) && (b <= 8'hbf);
        end else if (r_held_count == 2'd1 && lead == 8'hf4) begin
            ok = (b >= 8'h80) && (b <= 8'h8f);
        end else begin
            ok = b[7:6] == 2'b10;
        end

        unique case (b)
            8'h22:   esc = 8'h22;
            8'h5c:   esc = 8'h5c;
            8'h08:   esc = 8'h62;
            8'h0c:   esc = 8'h66;
            8'h0a:   esc = 8'h6e;
            8'h0d:   esc = 8'h72;
            8'h09:   esc = 8'h74;
            default: esc = 8'h00;
        endcase

        held_mode    = M_NONE;
        b_mode       = M_NONE;
        b_data       = b;
        n_held_count = r_held_count;
        n_seq_len    = r_seq_len;
        n_store      = 1'b0;
        n_store_idx  = r_held_count;

        if (i_item.carries_byte) begin
            if (pending && ok) begin
                if (({1'b0, r_held_count} + 3'd1) >= r_seq_len) begin
                    held_mode    = M_RAW;
                    b_mode       = M_RAW;
                    n_held_count = 2'd0;
                    n_seq_len    = 3'd0;
                end else if (i_item.end_of_string) begin
                    held_mode = M_HEX;
                    b_mode    = M_HEX;
                end else begin
                    n_store      = 1'b1;
                    n_held_count = r_held_count + 2'd1;
                end
            end else begin
                if (pending) begin
                    held_mode = M_HEX;
                end
                n_held_count = 2'd0;
                n_seq_len    = 3'd0;
                if (esc != 8'h00) begin
                    b_mode = M_SHORT;
                    b_data = esc;
                end else if (b < 8'h20) begin
                    b_mode = M_HEX;
                end else if (b < 8'h80) begin
                    b_mode = M_RAW;
                end else if (is_lead) begin
                    if (i_item.end_of_string) begin
                        b_mode = M_HEX;
                    end else begin
                        n_store      = 1'b1;
                        n_store_idx  = 2'd0;
                        n_held_count = 2'd1;
                        n_seq_len    = lead_len;
                    end
                end else begin
                    b_mode = M_HEX;
                end
            end
        end else if (i_item.end_of_string && pending) begin
            held_mode = M_HEX;
        end

        if (i_item.end_of_string) begin
            n_held_count = 2'd0;
            n_seq_len    = 3'd0;
        end

        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_plan.slots[i].mode = M_NONE;
            n_plan.slots[i].data = b;
        end
        if (!r_inside) begin
            n_plan.slots[SLOT_OPEN].mode = M_QUOTE;
        end
        for (int i = 0; i < NUM_HELD; i++) begin
            n_plan.slots[SLOT_H0 + 3'(i)].data = r_held[i];
            if (2'(i) < r_held_count) begin
                n_plan.slots[SLOT_H0 + 3'(i)].mode = held_mode;
            end
        end
        n_plan.slots[SLOT_B].mode = b_mode;
        n_plan.slots[SLOT_B].data = b_data;
        if (i_item.end_of_string) begin
            n_plan.slots[SLOT_CLOSE].mode = M_QUOTE;
        end
        n_inside = !i_item.end_of_string;
    end

    always_comb begin
        any_slot = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (n_plan.slots[i].mode != M_NONE) begin
                any_slot = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_seq_len    <= 3'd0;
            r_inside     <= 1'b0;
            r_plan_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_held_count <= n_held_count;
                r_seq_len    <= n_seq_len;
                r_inside     <= n_inside;
                r_plan_valid <= any_slot;
            end else if (i_take) begin
                r_plan_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plan <= n_plan;
            if (n_store) begin
                r_held[n_store_idx] <= i_item.data_byte;
            end
        end
    end

    assign o_plan_valid = r_plan_valid;
    assign o_plan       = r_plan;

endmodule

@@ rtl/core/jse_emit.sv @@
module jse_emit
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_plan_valid,
    input  t_plan      i_plan,
    output logic       o_take,
    jse_out_if.source  o_result
);

    logic [NUM_SLOTS-1:0] r_done;
    logic [2:0]           r_sub;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;
    logic                 r_out_closed;

    logic [NUM_SLOTS-1:0] active;
    logic [NUM_SLOTS-1:0] rest;
    t_slot_idx            cur;
    t_slot                cur_slot;
    logic                 slot_last;
    logic                 item_last;
    logic                 load;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            active[i] = (i_plan.slots[i].mode != M_NONE) && !r_done[i];
        end
        cur = SLOT_OPEN;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (active[i]) begin
                cur = t_slot_idx'(i);
            end
        end
        rest      = active & ~(NUM_SLOTS'(1) << cur);
        cur_slot  = i_plan.slots[cur];
        slot_last = r_sub == (slot_len(cur_slot.mode) - 3'd1);
        item_last = slot_last && (rest == '0);
    end

    assign load   = i_plan_valid && (!r_out_valid || o_result.ready);
    assign o_take = load && item_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_sub       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (item_last) begin
                    r_done <= '0;
                    r_sub  <= 3'd0;
                end else if (slot_last) begin
                    r_done[cur] <= 1'b1;
                    r_sub       <= 3'd0;
                end else begin
                    r_sub <= r_sub + 3'd1;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte   <= slot_byte(cur_slot.mode, cur_slot.data, r_sub);
            r_out_last   <= item_last;
            r_out_closed <= cur == SLOT_CLOSE;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.out_byte      = r_out_byte;
    assign o_result.last_of_run   = r_out_last;
    assign o_result.string_closed = r_out_closed;

endmodule

@@ rtl/core/json_string_escape_utf8_core.sv @@
// Channel   Direction  Payload
// i_item    in         data_byte[7:0], carries_byte, end_of_string
// o_result  out        out_byte[7:0], last_of_run, string_closed
//
// A transaction on i_item is decoded combinationally into a plan register; the plan
// is then sent out one byte per cycle, while o_result is ready, through a registered output.
// An item producing one byte sustains one transaction per cycle while o_result is ready;
// a longer item holds the plan register, and i_item off, until its last byte is loaded.
// Reset is synchronous and active low; it clears the open-string flag and drops held bytes.
// Stalls on o_result propagate back to i_item through the plan register.
module json_string_escape_utf8_core
    import jse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jse_in_if.sink    i_item,
    jse_out_if.source o_result
);

    logic  plan_valid;
    logic  take;
    t_plan plan;

    jse_plan u_plan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_take       (take),
        .o_plan_valid (plan_valid),
        .o_plan       (plan)
    );

    jse_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (plan_valid),
        .i_plan       (plan),
        .o_take       (take),
        .o_result     (o_result)
    );

endmodule
